// File: design/csm_pkg.sv
// Shared types, register codes and helpers for the caseless substring matcher.
`timescale 1ns / 1ps

package csm_pkg;

  localparam int KEY_BYTES  = 32;
  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = 64;
  localparam int LEN_W      = 6;
  localparam int IDX_W      = 3;
  localparam int CHAR_W     = 8;
  localparam int OUT_CNT_W  = 16;

  localparam logic [IDX_W-1:0] REG_WORD0  = 3'd0;
  localparam logic [IDX_W-1:0] REG_WORD1  = 3'd1;
  localparam logic [IDX_W-1:0] REG_WORD2  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WORD3  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LENGTH = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_TERM = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UZ   = 8'h5a;
  localparam logic [CHAR_W-1:0] CASE_OFS  = 8'h20;

  // Decoded keyword, one lane per keyword byte
  typedef struct packed {
    logic [KEY_BYTES-1:0][CHAR_W-1:0] key;
    logic [KEY_BYTES-1:0]             active;
    logic [KEY_BYTES-1:0]             last;
  } kw_cfg_t;

  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CHAR_UA && c <= CHAR_UZ) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage

// File: design/csm_cfg.sv
// Keyword registers and per-lane decode (folded bytes, active and last masks).
`timescale 1ns / 1ps

module csm_cfg #(
  parameter int LANES = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [csm_pkg::IDX_W-1:0]      cfg_index,
  input  logic [csm_pkg::WORD_W-1:0]     cfg_data,
  output csm_pkg::kw_cfg_t               dec
);

  logic [3:0][csm_pkg::WORD_W-1:0] words;
  logic [csm_pkg::LEN_W-1:0]       len;
  csm_pkg::kw_cfg_t                dec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      words <= '0;
      len   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        csm_pkg::REG_WORD0:  words[0] <= cfg_data;
        csm_pkg::REG_WORD1:  words[1] <= cfg_data;
        csm_pkg::REG_WORD2:  words[2] <= cfg_data;
        csm_pkg::REG_WORD3:  words[3] <= cfg_data;
        csm_pkg::REG_LENGTH: len      <= cfg_data[csm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // keyword ends at min(len, LANES) or at its first zero byte
  always_comb begin
    logic run;
    logic [csm_pkg::CHAR_W-1:0] b;
    dec_next = '0;
    run = 1'b1;
    for (int i = 0; i < csm_pkg::KEY_BYTES; i++) begin
      b = words[i / csm_pkg::WORD_BYTES][(i % csm_pkg::WORD_BYTES)*8 +: 8];
      dec_next.key[i] = csm_pkg::fold(b);
      run = run && (b != csm_pkg::CHAR_TERM) && (csm_pkg::LEN_W'(i) < len) && (i < LANES);
      dec_next.active[i] = run;
    end
    for (int i = 0; i < csm_pkg::KEY_BYTES - 1; i++) begin
      dec_next.last[i] = dec_next.active[i] && !dec_next.active[i+1];
    end
    dec_next.last[csm_pkg::KEY_BYTES-1] = dec_next.active[csm_pkg::KEY_BYTES-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec <= '0;
    end else begin
      dec <= dec_next;
    end
  end

endmodule

// File: design/csm_cell.sv
// One shift-and cell: holds one progress bit and compares one keyword byte.
`timescale 1ns / 1ps

module csm_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          clr,
  input  logic [csm_pkg::CHAR_W-1:0]    ch,
  input  logic [csm_pkg::CHAR_W-1:0]    key,
  input  logic                          active,
  input  logic                          prev,
  output logic                          bit_q,
  output logic                          bit_next
);

  assign bit_next = prev && active && (key == ch);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_q <= 1'b0;
    end else if (clr) begin
      bit_q <= 1'b0;
    end else if (step) begin
      bit_q <= bit_next;
    end
  end

endmodule

// File: design/caseless_substring_matcher_unit.sv
// Top level: input stage, row of shift-and cells, match counter and result register.
// A terminator byte passes through the input register (v1, c1) and then the result register (m_tvalid, m_tdata).
// Throughput: one name byte per cycle unless a result beat stalls; the cell row updates every progress bit per byte.
// s_tready is low only while a result beat waits and m_tready is low.
// rst (synchronous) clears progress, flags, the count, the keyword and pending beats.
// Keyword writes reach the cells through the keyword registers and then the decode register.
`timescale 1ns / 1ps

module caseless_substring_matcher_unit #(
  parameter int PATTERN_MAX = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] character
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // [0] matched, [16:1] match_count, zero pad
  input  logic                          cfg_we,
  input  logic [csm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [csm_pkg::WORD_W-1:0]    cfg_data
);

  localparam int LANES = (PATTERN_MAX < csm_pkg::KEY_BYTES) ? PATTERN_MAX : csm_pkg::KEY_BYTES;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  csm_pkg::kw_cfg_t dec;

  logic                          advance;
  logic                          v1;
  logic [csm_pkg::CHAR_W-1:0]    c1;
  logic                          term;
  logic                          step;
  logic                          clr;
  logic [LANES-1:0]              prog_q;
  logic [LANES-1:0]              prog_next;
  logic                          found;
  logic                          found_next;
  logic                          nonempty;
  logic                          hit;
  logic [COUNT_WIDTH-1:0]        cnt;
  logic [COUNT_WIDTH-1:0]        cnt_next;
  logic [31:0]                   cnt_wide;
  logic                          out_matched;
  logic [csm_pkg::OUT_CNT_W-1:0] out_count;

  csm_cfg #(.LANES(LANES)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dec       (dec)
  );

  assign advance = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1 <= csm_pkg::fold(s_tdata);
    end
  end

  assign term = (c1 == csm_pkg::CHAR_TERM);
  assign step = advance && v1 && !term;
  assign clr  = advance && v1 && term;

  for (genvar i = 0; i < LANES; i++) begin : g_cell
    csm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (step),
      .clr      (clr),
      .ch       (c1),
      .key      (dec.key[i]),
      .active   (dec.active[i]),
      .prev     ((i == 0) ? 1'b1 : prog_q[(i == 0) ? 0 : i-1]),
      .bit_q    (prog_q[i]),
      .bit_next (prog_next[i])
    );
  end

  // empty keyword: every byte completes a match
  assign found_next = found || !dec.active[0] || (|(prog_next & dec.last[LANES-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      nonempty <= 1'b0;
    end else if (clr) begin
      found    <= 1'b0;
      nonempty <= 1'b0;
    end else if (step) begin
      found    <= found_next;
      nonempty <= 1'b1;
    end
  end

  assign hit = found && nonempty;

  always_comb begin
    cnt_next = cnt;
    if (hit && cnt != CNT_MAX) begin
      cnt_next = cnt + 1'b1;
    end
  end

  assign cnt_wide = 32'(cnt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (clr) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= v1 && term;
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      out_matched <= hit;
      out_count   <= cnt_wide[csm_pkg::OUT_CNT_W-1:0];
    end
  end

  assign m_tdata = {7'd0, out_count, out_matched};

endmodule
